>>> hdl/jrmpc_pkg.sv
package jrmpc_pkg;

  // request kinds
  localparam logic [2:0] KIND_START  = 3'd0;
  localparam logic [2:0] KIND_SAMPLE = 3'd1;
  localparam logic [2:0] KIND_STEP   = 3'd2;
  localparam logic [2:0] KIND_TICK   = 3'd3;
  localparam logic [2:0] KIND_HALT   = 3'd4;

  typedef enum logic [1:0] {
    ST_RUN  = 2'd0,
    ST_OK   = 2'd1,
    ST_FAIL = 2'd2,
    ST_IDLE = 2'd3
  } status_t;

  typedef enum logic {
    MODE_IDLE = 1'b0,
    MODE_RUN  = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    REG_GAIN        = 2'd0,
    REG_SPEED_LIMIT = 2'd1,
    REG_SPEED_FLOOR = 2'd2,
    REG_TOLERANCE   = 2'd3
  } reg_idx_t;

  // Q8.24 constants
  localparam logic signed [31:0] PI_Q824     = 32'sd52707179;
  localparam logic signed [31:0] NEG_PI_Q824 = -32'sd52707179;
  localparam logic signed [32:0] Q_MAX_X     = 33'sh0_7FFF_FFFF;
  localparam logic signed [32:0] Q_MIN_X     = 33'sh1_8000_0000;

  localparam logic [31:0] GAIN_RST        = 32'd16777216;
  localparam logic [30:0] SPEED_LIMIT_RST = 31'd16777216;
  localparam logic [30:0] SPEED_FLOOR_RST = 31'd0;
  localparam logic [30:0] TOLERANCE_RST   = 31'd292818;

  // step outcome after the state update
  typedef struct packed {
    status_t     status;
    logic        scale;
    logic        neg;
    logic [31:0] mag;
  } step_res_t;

  // after the gain multiply, already shifted down by 24
  typedef struct packed {
    status_t     status;
    logic        scale;
    logic        neg;
    logic [39:0] scaled;
  } scaled_res_t;

endpackage

>>> hdl/joint_relative_move_p_controller.sv
// Channel | Dir | Handshake           | Fields
// --------+-----+---------------------+------------------------------------------------------
// in_*    | in  | in_valid/in_ready   | kind, move_angle, time_limit, joint_position, position_ok
// out_*   | out | out_valid/out_ready | speed_command, status
// APB     | in  | psel/penable/pready | paddr[3:2]: gain, speed_limit, speed_floor, tolerance
//
// One request per cycle sustained while out_ready stays high. A result passes through the
// input register, state update, gain multiply and clamp before it leaves the output register.
// Only the state-update stage feeds back on itself; later stages carry results forward.
// Reset (rst_n low, synchronous): registers to defaults, mode idle, no sample held.
// Each stage moves when the next one is empty or moving, so bubbles collapse and
// requests keep coming in while a finished result waits on out_ready.
module joint_relative_move_p_controller
  import jrmpc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_kind,
  input  logic signed [31:0] in_move_angle,
  input  logic [19:0]        in_time_limit,
  input  logic signed [31:0] in_joint_position,
  input  logic               in_position_ok,

  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_speed_command,
  output logic [1:0]         out_status,

  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // ---------------- configuration registers ----------------
  logic [31:0] gain_r;
  logic [30:0] speed_limit_r;
  logic [30:0] speed_floor_r;
  logic [30:0] tolerance_r;
  reg_idx_t    reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r        <= GAIN_RST;
      speed_limit_r <= SPEED_LIMIT_RST;
      speed_floor_r <= SPEED_FLOOR_RST;
      tolerance_r   <= TOLERANCE_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_GAIN:        gain_r        <= pwdata;
        REG_SPEED_LIMIT: speed_limit_r <= pwdata[30:0];
        REG_SPEED_FLOOR: speed_floor_r <= pwdata[30:0];
        REG_TOLERANCE:   tolerance_r   <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GAIN:        prdata = gain_r;
      REG_SPEED_LIMIT: prdata = {1'b0, speed_limit_r};
      REG_SPEED_FLOOR: prdata = {1'b0, speed_floor_r};
      REG_TOLERANCE:   prdata = {1'b0, tolerance_r};
      default:         prdata = '0;
    endcase
  end

  // ---------------- pipeline handshake ----------------
  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic s2_ready, s3_ready, s4_ready;
  logic s1_take;

  assign s4_ready  = !out_v_r || out_ready;
  assign s3_ready  = !s3_v_r || s4_ready;
  assign s2_ready  = !s2_v_r || s3_ready;
  assign s1_take   = s1_v_r && s2_ready;
  assign in_ready  = !s1_v_r || s2_ready;
  assign out_valid = out_v_r;

  // ---------------- stage 1: input register ----------------
  logic [2:0]         s1_kind_r;
  logic signed [31:0] s1_angle_r;
  logic [19:0]        s1_time_r;
  logic signed [31:0] s1_pos_r;
  logic               s1_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_v_r <= 1'b1;
    end else if (s1_take) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind_r  <= in_kind;
      s1_angle_r <= in_move_angle;
      s1_time_r  <= in_time_limit;
      s1_pos_r   <= in_joint_position;
      s1_ok_r    <= in_position_ok;
    end
  end

  // ---------------- stage 2: controller state ----------------
  mode_t              mode_r, mode_nxt;
  logic signed [31:0] move_amount_r, move_amount_nxt;
  logic signed [31:0] goal_r, goal_nxt;
  logic               goal_set_r, goal_set_nxt;
  logic signed [31:0] last_pos_r, last_pos_nxt;
  logic               last_pos_ok_r, last_pos_ok_nxt;
  logic [19:0]        time_left_r, time_left_nxt;

  logic signed [32:0] pos_x, move_x, goal_x, sum_x;
  logic signed [32:0] err_hi, err_lo, err_set, err, neg_err, tol_x, ntol_x;
  logic               ovf, in_band, cfg_ok, angle_ok;
  logic signed [31:0] goal_calc;
  logic [31:0]        mag;
  step_res_t          res;
  logic               res_v;

  // Goal latch and error are formed side by side: when the goal is not yet set,
  // the error is the requested move unless position plus move saturates.
  always_comb begin
    pos_x   = {last_pos_r[31], last_pos_r};
    move_x  = {move_amount_r[31], move_amount_r};
    goal_x  = {goal_r[31], goal_r};
    sum_x   = pos_x + move_x;
    ovf     = sum_x[32] != sum_x[31];
    goal_calc = ovf ? (sum_x[32] ? Q_MIN_X[31:0] : Q_MAX_X[31:0]) : sum_x[31:0];
    err_hi  = Q_MAX_X - pos_x;
    err_lo  = Q_MIN_X - pos_x;
    err_set = goal_x - pos_x;
    if (goal_set_r) begin
      err = err_set;
    end else if (ovf) begin
      err = sum_x[32] ? err_lo : err_hi;
    end else begin
      err = move_x;
    end
    neg_err = -err;
    mag     = err[32] ? neg_err[31:0] : err[31:0];
    tol_x   = {2'b00, tolerance_r};
    ntol_x  = -tol_x;
    in_band = (err <= tol_x) && (err >= ntol_x);
    cfg_ok  = (gain_r != '0) && (speed_limit_r != '0) &&
              (speed_floor_r <= speed_limit_r) && (tolerance_r != '0);
    angle_ok = (s1_angle_r <= PI_Q824) && (s1_angle_r >= NEG_PI_Q824);
  end

  always_comb begin
    mode_nxt        = mode_r;
    move_amount_nxt = move_amount_r;
    goal_nxt        = goal_r;
    goal_set_nxt    = goal_set_r;
    last_pos_nxt    = last_pos_r;
    last_pos_ok_nxt = last_pos_ok_r;
    time_left_nxt   = time_left_r;
    res             = '0;
    res.status      = ST_IDLE;
    res_v           = 1'b0;
    if (s1_take) begin
      case (s1_kind_r)
        KIND_START: begin
          res_v        = 1'b1;
          goal_set_nxt = 1'b0;
          goal_nxt     = '0;
          if (angle_ok && (s1_time_r != '0) && cfg_ok) begin
            move_amount_nxt = s1_angle_r;
            time_left_nxt   = s1_time_r;
            mode_nxt        = MODE_RUN;
            res.status      = ST_RUN;
          end else begin
            mode_nxt   = MODE_IDLE;
            res.status = ST_FAIL;
          end
        end
        KIND_SAMPLE: begin
          last_pos_nxt    = s1_pos_r;
          last_pos_ok_nxt = s1_ok_r;
        end
        KIND_STEP: begin
          res_v = 1'b1;
          if (mode_r != MODE_RUN) begin
            res.status = ST_IDLE;
          end else if (time_left_r == '0) begin
            mode_nxt   = MODE_IDLE;
            res.status = ST_FAIL;
          end else if (!last_pos_ok_r) begin
            res.status = ST_RUN;
          end else begin
            if (!goal_set_r) begin
              goal_nxt     = goal_calc;
              goal_set_nxt = 1'b1;
            end
            if (in_band) begin
              mode_nxt   = MODE_IDLE;
              res.status = ST_OK;
            end else begin
              res.status = ST_RUN;
              res.scale  = 1'b1;
              res.neg    = err[32];
              res.mag    = mag;
            end
          end
        end
        KIND_TICK: begin
          if ((mode_r == MODE_RUN) && (time_left_r != '0)) begin
            time_left_nxt = time_left_r - 20'd1;
          end
        end
        KIND_HALT: begin
          res_v        = 1'b1;
          mode_nxt     = MODE_IDLE;
          goal_set_nxt = 1'b0;
          res.status   = ST_IDLE;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_IDLE;
      move_amount_r <= '0;
      goal_r        <= '0;
      goal_set_r    <= 1'b0;
      last_pos_r    <= '0;
      last_pos_ok_r <= 1'b0;
      time_left_r   <= '0;
    end else begin
      mode_r        <= mode_nxt;
      move_amount_r <= move_amount_nxt;
      goal_r        <= goal_nxt;
      goal_set_r    <= goal_set_nxt;
      last_pos_r    <= last_pos_nxt;
      last_pos_ok_r <= last_pos_ok_nxt;
      time_left_r   <= time_left_nxt;
    end
  end

  step_res_t s2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_ready) begin
      s2_v_r <= s1_take && res_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_r <= res;
    end
  end

  // ---------------- stage 3: gain multiply ----------------
  logic [63:0] prod_full;
  scaled_res_t s3_r;

  // |err| * gain, truncated toward zero by dropping the 24 fraction bits
  assign prod_full = s2_r.mag * gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_ready) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready) begin
      s3_r.status <= s2_r.status;
      s3_r.scale  <= s2_r.scale;
      s3_r.neg    <= s2_r.neg;
      s3_r.scaled <= prod_full[63:24];
    end
  end

  // ---------------- stage 4: clamp, sign, output register ----------------
  logic [39:0]        lim_x;
  logic [30:0]        v_lim, v_flr;
  logic signed [31:0] spd_pos, spd;
  logic signed [31:0] out_speed_r;
  status_t            out_status_r;

  // limit first, then floor: a floor above the limit wins
  always_comb begin
    lim_x   = {9'd0, speed_limit_r};
    v_lim   = (s3_r.scaled > lim_x) ? speed_limit_r : s3_r.scaled[30:0];
    v_flr   = (v_lim < speed_floor_r) ? speed_floor_r : v_lim;
    spd_pos = {1'b0, v_flr};
    if (!s3_r.scale) begin
      spd = '0;
    end else if (s3_r.neg) begin
      spd = -spd_pos;
    end else begin
      spd = spd_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s4_ready) begin
      out_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_ready) begin
      out_speed_r  <= spd;
      out_status_r <= s3_r.status;
    end
  end

  assign out_speed_command = out_speed_r;
  assign out_status        = out_status_r;

`ifndef SYNTHESIS
  // only a running result carries a nonzero speed
  a_zero_speed_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_RUN) |-> out_speed_command == '0)
    else $error("nonzero speed on a non-running result");

  // the goal is latched only by a step taken while running
  a_goal_latch_running: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(goal_set_r) |-> $past(mode_r) == MODE_RUN)
    else $error("goal latched outside a running move");

  // an empty output register never blocks the input side
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");
`endif

endmodule

>>> dv/jrmpc_checker.sv
module jrmpc_checker
  import jrmpc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         in_kind,
  input  logic signed [31:0] in_move_angle,
  input  logic [19:0]        in_time_limit,
  input  logic signed [31:0] in_joint_position,
  input  logic               in_position_ok,

  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_speed_command,
  input  logic [1:0]         out_status,

  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,

  output int                 open_cmds,
  output int                 err_count
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] speed;
    status_t            status;
  } speed_cmd_t;

  // register copy
  logic [31:0]        gain_q;
  logic [30:0]        limit_q;
  logic [30:0]        floor_q;
  logic [30:0]        tol_q;

  // controller state
  mode_t              mode;
  logic signed [31:0] move_amt;
  logic signed [31:0] goal;
  logic               goal_set;
  logic signed [31:0] last_pos;
  logic               last_pos_ok;
  logic [19:0]        time_left;

  speed_cmd_t         cmds_due[$];
  speed_cmd_t         want;
  int                 errs;

  function automatic void push_cmd(input logic signed [31:0] speed, input status_t st);
    cmds_due.push_back('{speed, st});
  endfunction

  // one request against the controller state; queues any command it produces
  task automatic advance_controller(input logic [2:0] kind, input logic signed [31:0] angle,
                                    input logic [19:0] tlim, input logic signed [31:0] pos,
                                    input logic pos_ok);
    logic signed [32:0] sum;
    logic signed [32:0] err;
    logic [32:0]        mag;
    logic [64:0]        prod;
    logic [40:0]        spd;
    case (kind)
      KIND_START: begin
        goal_set = 1'b0;
        goal     = '0;
        if (angle > PI_Q824 || angle < NEG_PI_Q824 || tlim == '0 || gain_q == '0 ||
            limit_q == '0 || floor_q > limit_q || tol_q == '0) begin
          mode = MODE_IDLE;
          push_cmd('0, ST_FAIL);
        end else begin
          move_amt  = angle;
          time_left = tlim;
          mode      = MODE_RUN;
          push_cmd('0, ST_RUN);
        end
      end
      KIND_SAMPLE: begin
        last_pos    = pos;
        last_pos_ok = pos_ok;
      end
      KIND_TICK: begin
        if (mode == MODE_RUN && time_left != '0) time_left = time_left - 20'd1;
      end
      KIND_HALT: begin
        mode     = MODE_IDLE;
        goal_set = 1'b0;
        push_cmd('0, ST_IDLE);
      end
      KIND_STEP: begin
        if (mode != MODE_RUN) begin
          push_cmd('0, ST_IDLE);
        end else if (time_left == '0) begin
          mode = MODE_IDLE;
          push_cmd('0, ST_FAIL);
        end else if (!last_pos_ok) begin
          push_cmd('0, ST_RUN);
        end else begin
          if (!goal_set) begin
            sum = {last_pos[31], last_pos} + {move_amt[31], move_amt};
            if (sum > Q_MAX_X) sum = Q_MAX_X;
            if (sum < Q_MIN_X) sum = Q_MIN_X;
            goal     = sum[31:0];
            goal_set = 1'b1;
          end
          err = {goal[31], goal} - {last_pos[31], last_pos};
          mag = err[32] ? -err : err;
          if (mag <= {2'b00, tol_q}) begin
            mode = MODE_IDLE;
            push_cmd('0, ST_OK);
          end else begin
            prod = {32'd0, mag} * {33'd0, gain_q};
            spd  = prod[64:24];
            if (spd > {10'd0, limit_q}) spd = {10'd0, limit_q};
            if (spd < {10'd0, floor_q}) spd = {10'd0, floor_q};
            push_cmd(err[32] ? -spd[31:0] : spd[31:0], ST_RUN);
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      gain_q      = GAIN_RST;
      limit_q     = SPEED_LIMIT_RST;
      floor_q     = SPEED_FLOOR_RST;
      tol_q       = TOLERANCE_RST;
      mode        = MODE_IDLE;
      move_amt    = '0;
      goal        = '0;
      goal_set    = 1'b0;
      last_pos    = '0;
      last_pos_ok = 1'b0;
      time_left   = '0;
      errs        = 0;
      cmds_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_GAIN:        gain_q  = pwdata;
          REG_SPEED_LIMIT: limit_q = pwdata[30:0];
          REG_SPEED_FLOOR: floor_q = pwdata[30:0];
          REG_TOLERANCE:   tol_q   = pwdata[30:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (cmds_due.size() == 0) begin
          $display("%0t: unexpected command, got speed %0d status %0d",
                   $time, out_speed_command, out_status);
          errs++;
        end else begin
          want = cmds_due.pop_front();
          if (out_speed_command !== want.speed) begin
            $display("%0t: speed_command mismatch, expected %0d, got %0d",
                     $time, want.speed, out_speed_command);
            errs++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, out_status);
            errs++;
          end
        end
      end
      if (in_valid && in_ready)
        advance_controller(in_kind, in_move_angle, in_time_limit, in_joint_position,
                           in_position_ok);
    end
    open_cmds <= cmds_due.size();
    err_count <= errs;
  end

endmodule

>>> dv/tb_joint_relative_move_p_controller.sv
// Stimulus and verdict for the relative joint move controller. The checker beside the
// block tracks every accepted request and command; this module only drives the
// request channel, the command ready and the register port.
module tb_joint_relative_move_p_controller
  import jrmpc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT     = 500000;
  localparam int SETTLE_CYCLES   = 8;    // pad it past the pipeline depth
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int BLOCK_REQS      = 175;

  typedef struct packed {
    logic [31:0] gain;
    logic [30:0] limit;
    logic [30:0] floor;
    logic [30:0] tol;
  } ctrl_cfg_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         in_kind;
  logic signed [31:0] in_move_angle;
  logic [19:0]        in_time_limit;
  logic signed [31:0] in_joint_position;
  logic               in_position_ok;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_speed_command;
  logic [1:0]         out_status;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  int                 open_cmds;
  int                 err_count;

  // idle mix per phase: percent of cycles the sender sits out / the receiver stalls
  int                 gap_tbl[4]   = '{0, 63, 0, 12};
  int                 stall_tbl[4] = '{0, 0, 63, 12};
  int                 gap_pct;
  int                 stall_pct;
  bit                 hold_off_req;
  int                 reqs_sent;
  int                 block_end;
  int                 cycle_count;
  ctrl_cfg_t          cur_cfg;
  ctrl_cfg_t          cfg_set[5];

  joint_relative_move_p_controller dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_move_angle    (in_move_angle),
    .in_time_limit    (in_time_limit),
    .in_joint_position(in_joint_position),
    .in_position_ok   (in_position_ok),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_speed_command(out_speed_command),
    .out_status       (out_status),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  jrmpc_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_move_angle    (in_move_angle),
    .in_time_limit    (in_time_limit),
    .in_joint_position(in_joint_position),
    .in_position_ok   (in_position_ok),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_speed_command(out_speed_command),
    .out_status       (out_status),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .open_cmds        (open_cmds),
    .err_count        (err_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Command receiver. A hold-off request freezes ready low for a long stretch so the
  // pipeline backs up into in_ready while the sender keeps pushing.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Watchdog: runs out only when something hangs.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** joint_relative_move_p_controller: FAILED **");
    $finish;
  end

  // One request. Valid stays up from the previous request unless a gap is drawn, so
  // back-to-back requests never drop valid within a step.
  task automatic send_req(input logic [2:0] kind, input logic [31:0] angle,
                          input logic [19:0] tlim, input logic [31:0] pos, input logic ok);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_kind           <= kind;
    in_move_angle     <= angle;
    in_time_limit     <= tlim;
    in_joint_position <= pos;
    in_position_ok    <= ok;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    reqs_sent++;
  endtask

  // fields a request kind ignores are filled with noise
  task automatic send_start(input logic [31:0] angle, input logic [19:0] tlim);
    send_req(KIND_START, angle, tlim, $urandom, 1'($urandom));
  endtask

  task automatic send_sample(input logic [31:0] pos, input logic ok);
    send_req(KIND_SAMPLE, $urandom, 20'($urandom), pos, ok);
  endtask

  task automatic send_kind(input logic [2:0] kind);
    send_req(kind, $urandom, 20'($urandom), $urandom, 1'($urandom));
  endtask

  // Drop valid and wait until every command has come back, then let requests that
  // produce no command clear the pipeline too.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (open_cmds != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // setup phase, access phase, then the bus goes idle before anything else
  task automatic apb_write(input reg_idx_t idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input ctrl_cfg_t c);
    wait_idle();
    apb_write(REG_GAIN, c.gain);
    apb_write(REG_SPEED_LIMIT, {1'b0, c.limit});
    apb_write(REG_SPEED_FLOOR, {1'b0, c.floor});
    apb_write(REG_TOLERANCE, {1'b0, c.tol});
    cur_cfg = c;
  endtask

  // A move: start, a first sample, then samples closing in on the goal mixed with
  // steps, ticks and the odd halt or stray request.
  task automatic run_episode();
    logic signed [31:0] base;
    logic signed [31:0] ang;
    logic [19:0]        tlim;
    longint             target;
    longint             resid;
    int                 pick;
    int                 n_act;

    pick = $urandom_range(0, 99);
    if (pick < 60)
      base = $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
    else if (pick < 80)
      base = $urandom;
    else if (pick[0])
      base = 32'h7FFF_FFFF - $urandom_range(0, 32'h0400_0000);
    else
      base = 32'h8000_0000 + $urandom_range(0, 32'h0400_0000);

    pick = $urandom_range(0, 99);
    if (pick < 80)      ang = $signed($urandom_range(0, 32'd105414358)) - PI_Q824;
    else if (pick < 85) ang = pick[0] ? PI_Q824 : NEG_PI_Q824;
    else                ang = $urandom;

    pick = $urandom_range(0, 99);
    if (pick < 70)      tlim = 20'($urandom_range(1, 40));
    else if (pick < 95) tlim = 20'($urandom);
    else                tlim = '0;

    send_start(ang, tlim);
    if ($urandom_range(0, 99) < 85) send_sample(base, 1'b1);
    else                            send_sample($urandom, 1'($urandom));

    target = longint'(base) + longint'(ang);
    n_act  = $urandom_range(1, 12);
    repeat (n_act) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        case ($urandom_range(0, 3))
          0: resid = 0;
          1: begin
            resid = longint'($urandom_range(0, cur_cfg.tol));
            if ($urandom_range(0, 1)) resid = -resid;
          end
          2: resid = (target - longint'(base)) >>> $urandom_range(0, 8);
          default: resid = longint'($signed($urandom));
        endcase
        send_sample(32'(target - resid), $urandom_range(0, 99) < 90);
      end else if (pick < 75) begin
        send_kind(KIND_STEP);
      end else if (pick < 90) begin
        send_kind(KIND_TICK);
      end else if (pick < 95) begin
        send_kind(KIND_HALT);
      end else begin
        send_kind(3'($urandom_range(0, 7)));
      end
    end
    send_kind(KIND_STEP);
  endtask

  initial begin
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_kind           <= KIND_TICK;
    in_move_angle     <= '0;
    in_time_limit     <= '0;
    in_joint_position <= '0;
    in_position_ok    <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    gap_pct      = 0;
    stall_pct    = 0;
    hold_off_req = 1'b0;
    reqs_sent    = 0;
    cfg_set[0] = '{GAIN_RST, SPEED_LIMIT_RST, SPEED_FLOOR_RST, TOLERANCE_RST};
    cfg_set[1] = '{32'hFFFF_FFFF, 31'h7FFF_FFFF, 31'd0, 31'd1};
    cfg_set[2] = '{32'd1, 31'd1, 31'd1, 31'h7FFF_FFFF};
    cfg_set[3] = '{32'h0040_0000, 31'h0200_0000, 31'h0010_0000, 31'h0001_0000};
    cur_cfg    = cfg_set[0];

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed, reset register values ---
    send_kind(KIND_STEP);                        // step while idle
    send_kind(KIND_HALT);
    send_start(PI_Q824, 20'd1);
    send_kind(KIND_STEP);                        // running, no sample yet
    send_sample(32'sd0, 1'b1);
    send_kind(KIND_STEP);                        // error of pi, clamped at speed limit
    send_kind(KIND_TICK);
    send_kind(KIND_TICK);                        // timer already at zero, holds
    send_kind(KIND_STEP);                        // timeout
    send_start(PI_Q824 + 32'sd1, 20'd5);         // angle just past +pi
    send_start(NEG_PI_Q824 - 32'sd1, 20'd5);     // angle just past -pi
    send_start(32'h8000_0000, 20'd5);
    send_start(32'sd0, 20'd0);                   // zero timeout
    send_start(NEG_PI_Q824, 20'hF_FFFF);
    send_sample(32'h8000_0000, 1'b1);
    send_kind(KIND_STEP);                        // goal saturates low, arrives at once
    send_start(PI_Q824, 20'hF_FFFF);
    send_sample(32'h7FFF_FFFF, 1'b1);
    send_kind(KIND_STEP);                        // goal saturates high
    send_start(32'sd1000, 20'd3);
    send_sample($urandom, 1'b0);
    send_kind(KIND_STEP);                        // sample marked missing
    send_sample(32'sd0, 1'b1);
    send_kind(KIND_STEP);                        // inside tolerance, success
    send_start(NEG_PI_Q824, 20'd50);
    send_kind(KIND_STEP);                        // negative error, negative speed
    send_kind(KIND_HALT);
    send_kind(KIND_STEP);
    send_kind(3'd5);                             // undefined kinds are dropped
    send_kind(3'd6);
    send_kind(3'd7);

    // --- register changes while a move is live, and start-time register checks ---
    send_start(PI_Q824 >>> 1, 20'd100);
    send_sample(32'sd0, 1'b1);
    send_kind(KIND_STEP);
    wait_idle();
    apb_write(REG_SPEED_FLOOR, 32'h0200_0000);  // floor above limit, not re-checked
    send_kind(KIND_STEP);
    wait_idle();
    apb_write(REG_GAIN, 32'd0);                 // zero gain: speed falls to the floor
    send_kind(KIND_STEP);
    send_start(32'sd0, 20'd10);                 // rejected: zero gain, floor above limit
    wait_idle();
    apb_write(REG_GAIN, GAIN_RST);
    send_start(32'sd0, 20'd10);                 // rejected: floor above limit alone
    wait_idle();
    apb_write(REG_SPEED_FLOOR, 32'd0);
    apb_write(REG_SPEED_LIMIT, 32'd0);
    send_start(32'sd0, 20'd10);                 // rejected: zero limit
    wait_idle();
    apb_write(REG_SPEED_LIMIT, {1'b0, SPEED_LIMIT_RST});
    apb_write(REG_TOLERANCE, 32'd0);
    send_start(32'sd0, 20'd10);                 // rejected: zero tolerance
    send_kind(KIND_STEP);

    // --- random moves, one register setting and idle mix per block ---
    for (int blk = 0; blk < 8; blk++) begin
      if (blk % 5 == 4) begin
        cfg_set[4].gain  = $urandom | 32'd1;
        cfg_set[4].limit = 31'($urandom_range(1, 32'h7FFF_FFFF));
        cfg_set[4].floor = 31'($urandom_range(0, cfg_set[4].limit));
        cfg_set[4].tol   = 31'($urandom_range(1, 32'h0100_0000));
      end
      set_config(cfg_set[blk % 5]);             // sender waits here for every command
      gap_pct   = gap_tbl[blk % 4];
      stall_pct = stall_tbl[blk % 4];
      if (blk == 0) hold_off_req = 1'b1;        // back the pipeline up once
      block_end = reqs_sent + BLOCK_REQS;
      while (reqs_sent < block_end) run_episode();
    end

    wait_idle();
    @(posedge clk);
    if (err_count == 0 && open_cmds == 0)
      $display("** joint_relative_move_p_controller: PASSED **");
    else
      $display("** joint_relative_move_p_controller: FAILED **");
    $finish;
  end

endmodule
